[sv/path_hash_bucket_insert_defines.svh]
// assertion macros shared by the path hash bucket insert design
`ifndef PATH_HASH_BUCKET_INSERT_DEFINES_SVH
`define PATH_HASH_BUCKET_INSERT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PHBI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("phbi assertion failed");

// next-cycle implication, checked outside reset
`define PHBI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("phbi assertion failed");

`endif

[sv/phbi_pkg.sv]
// shared constants and types for the path hash bucket insert design
package phbi_pkg;

    localparam int HASH_W     = 32;
    localparam int UNIT_W     = 16;
    localparam int INDEX_W    = 12;
    localparam int DIR_CNT_W  = 11;
    localparam int FILE_CNT_W = 13;
    localparam int CFG_DATA_W = 13;
    localparam int ROT_RIGHT  = 5;

    typedef logic [HASH_W-1:0] word_t;

    localparam word_t HASH_SEED  = 32'd123456789;
    localparam word_t EMPTY_HEAD = 32'hffff_ffff;

    localparam logic REG_DIR_COUNT  = 1'b0;
    localparam logic REG_FILE_COUNT = 1'b1;

    localparam logic [DIR_CNT_W-1:0]  DIR_COUNT_RESET  = 11'd3;
    localparam logic [FILE_CNT_W-1:0] FILE_COUNT_RESET = 13'd3;

endpackage

[sv/path_hash_bucket_insert.sv]
// path hash bucket insert: rotate-xor name hash and chained bucket head update
//
// usage: a name enters as transactions on the in channel, one code unit each.
// first_unit seeds the hash from parent_offset, unit_valid folds code_unit in,
// last_unit ends the name and inserts entry_offset at the head of the bucket
// chain picked by hash modulo the bucket count of the selected table.
// that transaction yields one out transaction with bucket_index, name_hash
// and the old head in previous_head (all ones for an empty bucket).
// cfg writes set the two bucket counts at any time, cfg_ready is always high.
// a unit without last_unit is hashed as it is taken. a last unit holds in_ready
// low: the shared modulo unit retires one hash bit per cycle, then the bucket
// ram is read and written back, and the result is loaded into the output
// register. one name end is in flight at a time.
// after reset both bucket rams are swept to all ones, one entry per cycle,
// over the depth of the deeper table; in_ready stays low meanwhile.
// a stalled receiver holds the result in the output register; further units
// are still hashed, and the next name end waits before its write back.
`include "path_hash_bucket_insert_defines.svh"

module path_hash_bucket_insert #(
    parameter int DIR_BUCKETS  = 1024,
    parameter int FILE_BUCKETS = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [phbi_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            table_select,
    input  logic                            first_unit,
    input  logic [phbi_pkg::HASH_W-1:0]     parent_offset,
    input  logic                            unit_valid,
    input  logic [phbi_pkg::UNIT_W-1:0]     code_unit,
    input  logic                            last_unit,
    input  logic [phbi_pkg::HASH_W-1:0]     entry_offset,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [phbi_pkg::INDEX_W-1:0]    bucket_index,
    output logic [phbi_pkg::HASH_W-1:0]     name_hash,
    output logic [phbi_pkg::HASH_W-1:0]     previous_head
);
    import phbi_pkg::*;

    localparam int MAX_BUCKETS = (DIR_BUCKETS > FILE_BUCKETS) ? DIR_BUCKETS : FILE_BUCKETS;
    localparam int CNT_BITS    = $clog2(MAX_BUCKETS + 1);
    localparam int CNT_W       = (CNT_BITS > FILE_CNT_W) ? CNT_BITS : FILE_CNT_W;
    localparam int DIR_AW      = $clog2(DIR_BUCKETS);
    localparam int FILE_AW     = $clog2(FILE_BUCKETS);
    localparam int CLR_W       = $clog2(MAX_BUCKETS);

    localparam logic [CLR_W-1:0] CLR_LAST   = CLR_W'(MAX_BUCKETS - 1);
    localparam logic [CLR_W-1:0] CLR_ONE    = CLR_W'(1);
    localparam logic [CLR_W:0]   DIR_DEPTH  = (CLR_W + 1)'(DIR_BUCKETS);
    localparam logic [CLR_W:0]   FILE_DEPTH = (CLR_W + 1)'(FILE_BUCKETS);
    localparam logic [CNT_W-1:0] DIR_MAX    = CNT_W'(DIR_BUCKETS);
    localparam logic [CNT_W-1:0] FILE_MAX   = CNT_W'(FILE_BUCKETS);
    localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CLR_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [DIR_CNT_W-1:0]  dir_count_reg, dir_count_next;
    logic [FILE_CNT_W-1:0] file_count_reg, file_count_next;
    word_t                 hash_reg, hash_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  sel_reg;
    word_t                 entry_reg;
    word_t                 final_hash_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic [INDEX_W-1:0]    bucket_index_reg;
    word_t                 name_hash_reg;
    word_t                 previous_head_reg;

    word_t                 hash_seeded;
    word_t                 hash_new;
    logic                  in_fire;
    logic                  mod_start;
    logic                  mod_done;
    logic [CNT_W-1:0]      mod_rem;
    logic                  out_load;
    logic                  clearing;
    logic [CNT_W-1:0]      dir_ext, file_ext;
    logic [CNT_W-1:0]      dir_eff, file_eff, divisor_sel;

    logic                  dir_we, file_we, dir_re, file_re;
    logic [DIR_AW-1:0]     dir_waddr;
    logic [FILE_AW-1:0]    file_waddr;
    word_t                 ram_wdata;
    word_t                 dir_rdata, file_rdata;

    assign hash_seeded = first_unit ? (parent_offset ^ HASH_SEED) : hash_reg;
    assign hash_new    = unit_valid
        ? ({hash_seeded[ROT_RIGHT-1:0], hash_seeded[HASH_W-1:ROT_RIGHT]}
           ^ {{(HASH_W - UNIT_W){1'b0}}, code_unit})
        : hash_seeded;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign mod_start = in_fire && last_unit;
    assign out_load  = (state_reg == ST_WRITE) && (!out_valid_reg || out_ready);
    assign clearing  = (state_reg == ST_CLEAR);

    // bucket count zero acts as one, above the depth saturates
    assign dir_ext  = CNT_W'(dir_count_reg);
    assign file_ext = CNT_W'(file_count_reg);
    assign dir_eff  = (dir_ext == '0) ? CNT_ONE : ((dir_ext > DIR_MAX) ? DIR_MAX : dir_ext);
    assign file_eff = (file_ext == '0) ? CNT_ONE : ((file_ext > FILE_MAX) ? FILE_MAX : file_ext);
    assign divisor_sel = table_select ? file_eff : dir_eff;

    phbi_mod #(
        .CNT_W(CNT_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (hash_new),
        .divisor  (divisor_sel),
        .done     (mod_done),
        .remainder(mod_rem)
    );

    assign dir_we     = (clearing && ({1'b0, clr_cnt_reg} < DIR_DEPTH)) || (out_load && !sel_reg);
    assign file_we    = (clearing && ({1'b0, clr_cnt_reg} < FILE_DEPTH)) || (out_load && sel_reg);
    assign dir_waddr  = clearing ? clr_cnt_reg[DIR_AW-1:0] : idx_reg[DIR_AW-1:0];
    assign file_waddr = clearing ? clr_cnt_reg[FILE_AW-1:0] : idx_reg[FILE_AW-1:0];
    assign ram_wdata  = clearing ? EMPTY_HEAD : entry_reg;
    assign dir_re     = mod_done && !sel_reg;
    assign file_re    = mod_done && sel_reg;

    phbi_ram #(
        .WIDTH(HASH_W),
        .DEPTH(DIR_BUCKETS)
    ) u_dir_ram (
        .clk  (clk),
        .we   (dir_we),
        .waddr(dir_waddr),
        .wdata(ram_wdata),
        .re   (dir_re),
        .raddr(mod_rem[DIR_AW-1:0]),
        .rdata(dir_rdata)
    );

    phbi_ram #(
        .WIDTH(HASH_W),
        .DEPTH(FILE_BUCKETS)
    ) u_file_ram (
        .clk  (clk),
        .we   (file_we),
        .waddr(file_waddr),
        .wdata(ram_wdata),
        .re   (file_re),
        .raddr(mod_rem[FILE_AW-1:0]),
        .rdata(file_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + CLR_ONE;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (mod_start)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (mod_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        dir_count_next  = dir_count_reg;
        file_count_next = file_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DIR_COUNT:  dir_count_next  = cfg_data[DIR_CNT_W-1:0];
                REG_FILE_COUNT: file_count_next = cfg_data[FILE_CNT_W-1:0];
                default:        dir_count_next  = dir_count_reg;
            endcase
        end
    end

    assign hash_next = in_fire ? hash_new : hash_reg;

    always_comb
    begin
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            dir_count_reg  <= DIR_COUNT_RESET;
            file_count_reg <= FILE_COUNT_RESET;
            hash_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            dir_count_reg  <= dir_count_next;
            file_count_reg <= file_count_next;
            hash_reg       <= hash_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mod_start)
        begin
            sel_reg        <= table_select;
            entry_reg      <= entry_offset;
            final_hash_reg <= hash_new;
        end
        if (mod_done)
        begin
            idx_reg <= mod_rem;
        end
        if (out_load)
        begin
            bucket_index_reg  <= idx_reg[INDEX_W-1:0];
            name_hash_reg     <= final_hash_reg;
            previous_head_reg <= sel_reg ? file_rdata : dir_rdata;
        end
    end

    assign out_valid     = out_valid_reg;
    assign bucket_index  = bucket_index_reg;
    assign name_hash     = name_hash_reg;
    assign previous_head = previous_head_reg;

    `PHBI_ASSERT_IMPL(a_done_only_in_div, mod_done, state_reg == ST_DIV)
    `PHBI_ASSERT_NEXT(a_start_enters_div, mod_start, state_reg == ST_DIV && !in_ready)
    `PHBI_ASSERT_NEXT(a_load_shows_result, out_load, out_valid_reg && state_reg == ST_IDLE)

endmodule

[sv/phbi_ram.sv]
// generic simple dual-port ram with registered read
module phbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/phbi_mod.sv]
// iterative restoring modulo unit, one dividend bit per cycle
module phbi_mod #(
    parameter int CNT_W = 17
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [phbi_pkg::HASH_W-1:0] dividend,
    input  logic [CNT_W-1:0]          divisor,
    output logic                      done,
    output logic [CNT_W-1:0]          remainder
);
    import phbi_pkg::*;

    localparam int STEP_W = $clog2(HASH_W + 1);
    localparam logic [STEP_W-1:0] STEP_INIT = STEP_W'(HASH_W);
    localparam logic [STEP_W-1:0] STEP_ONE  = STEP_W'(1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    word_t             dvd_reg, dvd_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;

    logic [CNT_W:0]    rem_shift;
    logic [CNT_W:0]    rem_diff;
    logic [CNT_W-1:0]  rem_step;

    assign rem_shift = {rem_reg, dvd_reg[HASH_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign rem_step  = (rem_shift >= {1'b0, dsr_reg}) ? rem_diff[CNT_W-1:0]
                                                      : rem_shift[CNT_W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_INIT;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next  = {dvd_reg[HASH_W-2:0], 1'b0};
            rem_next  = rem_step;
            step_next = step_reg - STEP_ONE;
            if (step_reg == STEP_ONE)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[tb/sv/phbi_insert_checker.sv]
// checker for path_hash_bucket_insert: predicts bucket inserts and compares results
module phbi_insert_checker
    import phbi_pkg::*;
#(
    parameter int DIR_BUCKETS  = 1024,
    parameter int FILE_BUCKETS = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic                   table_select,
    input  logic                   first_unit,
    input  logic [HASH_W-1:0]      parent_offset,
    input  logic                   unit_valid,
    input  logic [UNIT_W-1:0]      code_unit,
    input  logic                   last_unit,
    input  logic [HASH_W-1:0]      entry_offset,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [INDEX_W-1:0]     bucket_index,
    input  logic [HASH_W-1:0]      name_hash,
    input  logic [HASH_W-1:0]      previous_head,
    output int                     fail_count,
    output int                     pending_inserts,
    output int                     inserts_seen
);

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        word_t              hash;
        word_t              prev;
    } insert_t;

    insert_t                 expected_inserts[$];
    insert_t                 got;
    insert_t                 want;
    word_t                   dir_heads[DIR_BUCKETS];
    word_t                   file_heads[FILE_BUCKETS];
    logic [DIR_CNT_W-1:0]    dir_count;
    logic [FILE_CNT_W-1:0]   file_count;
    word_t                   hash_acc;
    int unsigned             slot;

    function automatic int unsigned usable_buckets(int unsigned count, int unsigned depth);
        if (count == 0)
        begin
            return 1;
        end
        return (count > depth) ? depth : count;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_count  = DIR_COUNT_RESET;
            file_count = FILE_COUNT_RESET;
            hash_acc   = '0;
            foreach (dir_heads[i])
            begin
                dir_heads[i] = EMPTY_HEAD;
            end
            foreach (file_heads[i])
            begin
                file_heads[i] = EMPTY_HEAD;
            end
            expected_inserts.delete();
            fail_count      = 0;
            pending_inserts = 0;
            inserts_seen    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{bucket_index, name_hash, previous_head};
                inserts_seen++;
                if (expected_inserts.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected result: expected none, actual index %h hash %h head %h",
                             $time, got.index, got.hash, got.prev);
                end
                else
                begin
                    want = expected_inserts.pop_front();
                    if (got.index !== want.index)
                    begin
                        fail_count++;
                        $display("%0t bucket_index mismatch: expected %h actual %h",
                                 $time, want.index, got.index);
                    end
                    if (got.hash !== want.hash)
                    begin
                        fail_count++;
                        $display("%0t name_hash mismatch: expected %h actual %h",
                                 $time, want.hash, got.hash);
                    end
                    if (got.prev !== want.prev)
                    begin
                        fail_count++;
                        $display("%0t previous_head mismatch: expected %h actual %h",
                                 $time, want.prev, got.prev);
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_DIR_COUNT)
                begin
                    dir_count = cfg_data[DIR_CNT_W-1:0];
                end
                else
                begin
                    file_count = cfg_data[FILE_CNT_W-1:0];
                end
            end

            if (in_valid && in_ready)
            begin
                if (first_unit)
                begin
                    hash_acc = parent_offset ^ HASH_SEED;
                end
                if (unit_valid)
                begin
                    hash_acc = {hash_acc[ROT_RIGHT-1:0], hash_acc[HASH_W-1:ROT_RIGHT]}
                               ^ word_t'(code_unit);
                end
                if (last_unit)
                begin
                    if (table_select)
                    begin
                        slot = hash_acc % usable_buckets(32'(file_count), FILE_BUCKETS);
                        want.prev = file_heads[slot];
                        file_heads[slot] = entry_offset;
                    end
                    else
                    begin
                        slot = hash_acc % usable_buckets(32'(dir_count), DIR_BUCKETS);
                        want.prev = dir_heads[slot];
                        dir_heads[slot] = entry_offset;
                    end
                    want.index = slot[INDEX_W-1:0];
                    want.hash  = hash_acc;
                    expected_inserts.push_back(want);
                end
            end

            pending_inserts = expected_inserts.size();
        end
    end

endmodule

[tb/sv/tb_top.sv]
// testbench top for path_hash_bucket_insert: stimulus, flow control and verdict
module tb_top;
    import phbi_pkg::*;

    localparam int DIR_BUCKETS  = 1024;
    localparam int FILE_BUCKETS = 4096;
    localparam int LIMIT        = 300000;
    localparam int DRAIN        = 40;
    localparam int HOLD         = 300;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 50;
    localparam int MAX_NAME     = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  table_select;
    logic                  first_unit;
    word_t                 parent_offset;
    logic                  unit_valid;
    logic [UNIT_W-1:0]     code_unit;
    logic                  last_unit;
    word_t                 entry_offset;
    logic                  out_valid;
    logic                  out_ready;
    logic [INDEX_W-1:0]    bucket_index;
    word_t                 name_hash;
    word_t                 previous_head;

    int fail_count;
    int pending_inserts;
    int inserts_seen;
    int cycles;
    int items_sent;
    int settings_run;
    int hold_requests;
    int holds_done;
    bit tx_steady;
    bit rx_steady;

    word_t             name_parent;
    int                name_len;
    logic [UNIT_W-1:0] name_units[MAX_NAME];
    bit                name_valid[MAX_NAME];

    path_hash_bucket_insert #(
        .DIR_BUCKETS  (DIR_BUCKETS),
        .FILE_BUCKETS (FILE_BUCKETS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .table_select  (table_select),
        .first_unit    (first_unit),
        .parent_offset (parent_offset),
        .unit_valid    (unit_valid),
        .code_unit     (code_unit),
        .last_unit     (last_unit),
        .entry_offset  (entry_offset),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .bucket_index  (bucket_index),
        .name_hash     (name_hash),
        .previous_head (previous_head)
    );

    phbi_insert_checker #(
        .DIR_BUCKETS  (DIR_BUCKETS),
        .FILE_BUCKETS (FILE_BUCKETS)
    ) insert_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .table_select    (table_select),
        .first_unit      (first_unit),
        .parent_offset   (parent_offset),
        .unit_valid      (unit_valid),
        .code_unit       (code_unit),
        .last_unit       (last_unit),
        .entry_offset    (entry_offset),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .bucket_index    (bucket_index),
        .name_hash       (name_hash),
        .previous_head   (previous_head),
        .fail_count      (fail_count),
        .pending_inserts (pending_inserts),
        .inserts_seen    (inserts_seen)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic word_t pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return '0;
        end
        if (r == 1)
        begin
            return '1;
        end
        return $urandom;
    endfunction

    function automatic logic [UNIT_W-1:0] pick_unit();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return '0;
        end
        if (r == 1)
        begin
            return '1;
        end
        return UNIT_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_unit(input logic sel, input logic first, input word_t parent,
                             input logic valid, input logic [UNIT_W-1:0] unit,
                             input logic last, input word_t entry);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        table_select  <= sel;
        first_unit    <= first;
        parent_offset <= parent;
        unit_valid    <= valid;
        code_unit     <= unit;
        last_unit     <= last;
        entry_offset  <= entry;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // well-formed name, sometimes a replay of the previous one to build chains
    task automatic send_name(input bit seeded);
        logic sel;
        if ($urandom_range(0, 7) != 0)
        begin
            name_parent = pick_word();
            name_len    = $urandom_range(0, MAX_NAME);
            for (int i = 0; i < MAX_NAME; i++)
            begin
                name_units[i] = pick_unit();
                name_valid[i] = ($urandom_range(0, 9) != 0);
            end
        end
        sel = 1'($urandom_range(0, 1));
        if (name_len == 0)
        begin
            send_unit(sel, seeded, name_parent, 1'b0, pick_unit(), 1'b1, pick_word());
        end
        else
        begin
            for (int i = 0; i < name_len; i++)
            begin
                send_unit((i == name_len - 1) ? sel : logic'($urandom_range(0, 1)),
                          seeded && (i == 0), (i == 0) ? name_parent : pick_word(),
                          name_valid[i], name_units[i], i == name_len - 1, pick_word());
            end
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_inserts != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic write_counts(input logic [CFG_DATA_W-1:0] dir_val,
                                input logic [CFG_DATA_W-1:0] file_val);
        wait_idle();
        cfg_index <= REG_DIR_COUNT;
        cfg_data  <= dir_val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_index <= REG_FILE_COUNT;
        cfg_data  <= file_val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (holds_done != hold_requests)
            begin
                stall = HOLD;
                holds_done++;
            end
            else
            begin
                stall = rx_steady ? 0 : $urandom_range(0, 18);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] dir_setting;
        logic [CFG_DATA_W-1:0] file_setting;
        int                    r;

        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_DIR_COUNT;
        cfg_data      = '0;
        in_valid      = 1'b0;
        table_select  = 1'b0;
        first_unit    = 1'b0;
        parent_offset = '0;
        unit_valid    = 1'b0;
        code_unit     = '0;
        last_unit     = 1'b0;
        entry_offset  = '0;
        items_sent    = 0;
        settings_run  = 0;
        hold_requests = 0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        name_len      = 0;
        name_parent   = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // name without a first unit continues from the reset hash
        send_unit(1'b0, 1'b0, 32'h0, 1'b1, 16'hffff, 1'b1, 32'h0000_0001);
        // empty name twice into the same bucket
        send_unit(1'b1, 1'b1, 32'hffff_ffff, 1'b0, 16'h0000, 1'b1, 32'h0000_0000);
        send_unit(1'b1, 1'b1, 32'hffff_ffff, 1'b0, 16'h1234, 1'b1, 32'hffff_ffff);
        // invalid unit in the middle of a name
        send_unit(1'b0, 1'b1, 32'h0000_0000, 1'b1, 16'h0000, 1'b0, 32'h5555_5555);
        send_unit(1'b1, 1'b0, 32'haaaa_aaaa, 1'b0, 16'hffff, 1'b0, 32'haaaa_aaaa);
        send_unit(1'b0, 1'b0, 32'h5555_5555, 1'b1, 16'h8000, 1'b1, 32'h8000_0000);
        // single unit name
        send_unit(1'b0, 1'b1, 32'h8000_0001, 1'b1, 16'h0001, 1'b1, 32'h7fff_fffe);
        // reseed in the middle of a name
        send_unit(1'b1, 1'b1, 32'h1234_5678, 1'b1, 16'h00ff, 1'b0, 32'h0);
        send_unit(1'b1, 1'b1, 32'h8765_4321, 1'b1, 16'hff00, 1'b0, 32'h0);
        send_unit(1'b1, 1'b0, 32'h0, 1'b1, 16'h7fff, 1'b1, 32'hdead_beef);
        // a fragment that ends nothing, then a name that ends on a bare unit
        send_unit(1'b0, 1'b0, 32'hffff_ffff, 1'b1, 16'h5a5a, 1'b0, 32'hffff_ffff);
        send_unit(1'b0, 1'b0, 32'h0, 1'b0, 16'ha5a5, 1'b1, 32'h0bad_f00d);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin dir_setting = 0;    file_setting = 0;    end
                1: begin dir_setting = 1;    file_setting = 1;    end
                2: begin dir_setting = 2;    file_setting = 2;    end
                3: begin dir_setting = 1024; file_setting = 4096; end
                4: begin dir_setting = 2047; file_setting = 8191; end
                5: begin dir_setting = 3;    file_setting = 3;    end
                default:
                begin
                    dir_setting  = CFG_DATA_W'(($urandom_range(0, 3) == 0)
                                               ? $urandom_range(0, 8191)
                                               : $urandom_range(3, 1024));
                    file_setting = CFG_DATA_W'(($urandom_range(0, 3) == 0)
                                               ? $urandom_range(0, 8191)
                                               : $urandom_range(3, 4096));
                end
            endcase
            write_counts(dir_setting, file_setting);
            tx_steady = (p == 3) || (p == 7);
            rx_steady = (p == 7);
            if (p == 3)
            begin
                hold_requests++;
            end
            for (int k = 0; k < PHASE_ITEMS; )
            begin
                r = $urandom_range(0, 99);
                if (r < 12)
                begin
                    send_unit(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_word(),
                              1'($urandom_range(0, 1)), pick_unit(), 1'($urandom_range(0, 1)),
                              pick_word());
                    k++;
                end
                else
                begin
                    send_name(r >= 20);
                    k += (name_len == 0) ? 1 : name_len;
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_inserts != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
        $display("covered %0d input transactions and %0d bucket inserts", items_sent, inserts_seen);
        $display("over %0d bucket count settings, from zero up past the table depth",
                 settings_run);
        if (fail_count == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/phbi_pkg.sv
sv/phbi_ram.sv
sv/phbi_mod.sv
sv/path_hash_bucket_insert.sv
tb/sv/phbi_insert_checker.sv
tb/sv/tb_top.sv
